// ===== hw/rtl/sacm_pkg.sv =====
// Shared types and constants of the set-associative LRU cache model.
`timescale 1ns / 1ps
package sacm_pkg;

    localparam int OP_W    = 2;
    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 31;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int OUT_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Access codes.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_IGNORE = 2'd3;

    // Outcome codes of the first lookup.
    localparam logic [OUT_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUT_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUT_W-1:0] OUT_EVICT = 2'd2;
    localparam logic [OUT_W-1:0] OUT_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    localparam logic [2:0] SET_BITS_RESET   = 3'd4;
    localparam logic [3:0] WAYS_RESET       = 4'd1;
    localparam logic [4:0] BLOCK_BITS_RESET = 5'd4;

    // One cache line as stored in a row of the line memory.
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_WR
    } t_state;

endpackage

// ===== hw/rtl/sacm_if.sv =====
// Handshake interfaces for the access, result and configuration channels.
`timescale 1ns / 1ps
interface sacm_in_if ();
    logic                          valid;
    logic                          ready;
    logic [sacm_pkg::OP_W-1:0]     op;
    logic [sacm_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output op, output address, input ready);
    modport sink (input valid, input op, input address, output ready);
endinterface

interface sacm_out_if ();
    logic                          valid;
    logic                          ready;
    logic [sacm_pkg::OUT_W-1:0]    outcome;
    logic                          second_hit;
    logic [sacm_pkg::CNT_W-1:0]    hit_total;
    logic [sacm_pkg::CNT_W-1:0]    miss_total;
    logic [sacm_pkg::CNT_W-1:0]    evict_total;

    modport source (output valid, output outcome, output second_hit, output hit_total,
                    output miss_total, output evict_total, input ready);
    modport sink (input valid, input outcome, input second_hit, input hit_total,
                  input miss_total, input evict_total, output ready);
endinterface

interface sacm_cfg_if ();
    logic                              valid;
    logic                              ready;
    logic [sacm_pkg::CFG_IDX_W-1:0]    index;
    logic [sacm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/set_assoc_lru_cache_model.sv =====
// Set-associative cache model with timestamp LRU replacement; one item per trace access.
// Each set is one row of a single line memory that holds every way of the set (valid bit,
// tag and age stamp), so one lookup is one row read followed by one row write. The row is
// read at the edge that accepts an item; in the compare state the tags are compared and the
// fill or victim way is picked (a small combinational minimum tree over the stamps), and
// the write state writes the row back, bumps the totals and loads the result register. The
// result register lets the next item be accepted while a result still waits; the write-back
// state only stalls when that register is full and not being drained. A modify's store part
// always hits the line its load part just touched, so it costs no second row access. After
// reset every set reads as empty through a per-set flag, so no clearing pass is needed and
// items are taken as soon as reset is released. Configuration writes are taken at any time,
// but are meant to happen only while the block is idle.
`timescale 1ns / 1ps
module set_assoc_lru_cache_model #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sacm_in_if.sink     i_in,
    sacm_out_if.source  o_out,
    sacm_cfg_if.sink    i_cfg
);
    localparam int SW    = MAX_SET_BITS;
    localparam int SETS  = 1 << SW;
    localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NWW   = $clog2(MAX_WAYS + 1);
    localparam int SBW   = $clog2(MAX_SET_BITS + 1);
    localparam int LV    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
    localparam int P     = 1 << LV;
    localparam int LINE_W = $bits(sacm_pkg::t_line);
    localparam int ROW_W  = MAX_WAYS * LINE_W;

    // Configuration registers.
    logic [2:0] r_set_bits;
    logic [3:0] r_ways;
    logic [4:0] r_block_bits;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= sacm_pkg::SET_BITS_RESET;
            r_ways       <= sacm_pkg::WAYS_RESET;
            r_block_bits <= sacm_pkg::BLOCK_BITS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sacm_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg.data[2:0];
                sacm_pkg::CFG_WAYS:       r_ways       <= i_cfg.data[3:0];
                sacm_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Geometry, saturated into the supported range.
    logic [SBW-1:0] sb;
    logic [NWW-1:0] nw;

    always_comb begin
        if (r_set_bits == 3'd0) begin
            sb = SBW'(1);
        end else if (32'(r_set_bits) > 32'(MAX_SET_BITS)) begin
            sb = SBW'(MAX_SET_BITS);
        end else begin
            sb = SBW'(r_set_bits);
        end
        if (r_ways == 4'd0) begin
            nw = NWW'(1);
        end else if (32'(r_ways) > 32'(MAX_WAYS)) begin
            nw = NWW'(MAX_WAYS);
        end else begin
            nw = NWW'(r_ways);
        end
    end

    // Address split of the incoming item.
    logic [5:0]                  shift;
    logic [sacm_pkg::ADDR_W-1:0] addr_sh;
    logic [SW-1:0]               set_in;
    logic [sacm_pkg::TAG_W-1:0]  tag_in;

    always_comb begin
        shift   = 6'(sb) + 6'(r_block_bits);
        addr_sh = i_in.address >> r_block_bits;
        set_in  = addr_sh[SW-1:0] & ~({SW{1'b1}} << sb);
        if (shift >= 6'd32) begin
            tag_in = '0;
        end else begin
            tag_in = sacm_pkg::TAG_W'(i_in.address >> shift);
        end
    end

    // State machine.
    sacm_pkg::t_state r_state;
    sacm_pkg::t_state n_state;
    logic             accept;
    logic             slot_free;
    logic             commit;
    logic             row_we;

    assign accept    = i_in.valid && i_in.ready;
    assign slot_free = !o_out.valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sacm_pkg::S_IDLE: if (i_in.valid) n_state = sacm_pkg::S_CMP;
            sacm_pkg::S_CMP:  n_state = sacm_pkg::S_WR;
            sacm_pkg::S_WR:   if (slot_free) n_state = sacm_pkg::S_IDLE;
            default:          n_state = sacm_pkg::S_IDLE;
        endcase
    end

    // Item held between acceptance and write-back.
    logic [sacm_pkg::OP_W-1:0]  r_op;
    logic [SW-1:0]              r_set;
    logic [sacm_pkg::TAG_W-1:0] r_tag;
    logic                       r_row_hit;

    always_comb begin
        i_in.ready = 1'b0;
        commit     = 1'b0;
        case (r_state)
            sacm_pkg::S_IDLE: i_in.ready = 1'b1;
            sacm_pkg::S_CMP:  ;
            sacm_pkg::S_WR:   commit = slot_free;
            default:          ;
        endcase
        row_we = commit && (r_op != sacm_pkg::OP_IGNORE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Per-set flag: a set never written reads as all lines invalid with zero stamps.
    logic [SETS-1:0] r_row_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (row_we) begin
            r_row_ok[r_set] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_in.op;
            r_set     <= set_in;
            r_tag     <= tag_in;
            r_row_hit <= r_row_ok[set_in];
        end
    end

    // Line memory: one row per set.
    logic [ROW_W-1:0]                     ram_rdata;
    sacm_pkg::t_line [MAX_WAYS-1:0]       row;
    sacm_pkg::t_line [MAX_WAYS-1:0]       n_row;
    logic [sacm_pkg::STAMP_W-1:0]         r_time;

    assign row = r_row_hit ? ram_rdata : '0;

    sacm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_set),
        .i_wdata (n_row),
        .i_re    (accept),
        .i_raddr (set_in),
        .o_rdata (ram_rdata)
    );

    // Compare stage: hit search, fill search and oldest-stamp tree.
    logic [MAX_WAYS-1:0] used;
    logic                hit;
    logic                any_free;
    logic [WW-1:0]       hit_way;
    logic [WW-1:0]       free_way;
    logic [sacm_pkg::STAMP_W-1:0] e_st   [LV+1][P];
    logic [WW-1:0]                e_ix   [LV+1][P];
    logic                         e_live [LV+1][P];
    logic                         take_b;

    always_comb begin
        hit      = 1'b0;
        any_free = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            used[w] = (w < int'(nw));
        end
        // Lowest matching way wins.
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (used[w] && row[w].valid && (row[w].tag == r_tag)) begin
                hit     = 1'b1;
                hit_way = WW'(w);
            end
        end
        // Highest invalid way is filled.
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (used[w] && !row[w].valid) begin
                any_free = 1'b1;
                free_way = WW'(w);
            end
        end
        // Pairwise minimum; the lower index keeps a tie.
        for (int l = 0; l <= LV; l++) begin
            for (int i = 0; i < P; i++) begin
                e_st[l][i]   = '0;
                e_ix[l][i]   = WW'(i);
                e_live[l][i] = 1'b0;
            end
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            e_st[0][i]   = row[i].stamp;
            e_live[0][i] = used[i];
        end
        take_b = 1'b0;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < (P >> (l + 1)); i++) begin
                take_b = e_live[l][2*i+1] &&
                         (!e_live[l][2*i] || (e_st[l][2*i+1] < e_st[l][2*i]));
                e_st[l+1][i]   = take_b ? e_st[l][2*i+1] : e_st[l][2*i];
                e_ix[l+1][i]   = take_b ? e_ix[l][2*i+1] : e_ix[l][2*i];
                e_live[l+1][i] = e_live[l][2*i] || e_live[l][2*i+1];
            end
        end
    end

    logic [sacm_pkg::OUT_W-1:0] r_kind;
    logic [WW-1:0]              r_way;

    always_ff @(posedge i_clk) begin
        if (r_state == sacm_pkg::S_CMP) begin
            if (r_op == sacm_pkg::OP_IGNORE) begin
                r_kind <= sacm_pkg::OUT_NONE;
                r_way  <= '0;
            end else if (hit) begin
                r_kind <= sacm_pkg::OUT_HIT;
                r_way  <= hit_way;
            end else if (any_free) begin
                r_kind <= sacm_pkg::OUT_FILL;
                r_way  <= free_way;
            end else begin
                r_kind <= sacm_pkg::OUT_EVICT;
                r_way  <= e_ix[LV][0];
            end
        end
    end

    // Write-back: the touched way takes the current stamp.
    always_comb begin
        n_row               = row;
        n_row[r_way].valid  = 1'b1;
        n_row[r_way].tag    = r_tag;
        n_row[r_way].stamp  = r_time;
    end

    // Totals, time stamp and result register.
    logic [sacm_pkg::CNT_W-1:0] r_hits;
    logic [sacm_pkg::CNT_W-1:0] r_misses;
    logic [sacm_pkg::CNT_W-1:0] r_evicts;
    logic                       r_out_valid;
    logic [sacm_pkg::OUT_W-1:0] r_outcome;
    logic                       r_second;
    logic                       is_mod;
    logic [1:0]                 hit_inc;

    always_comb begin
        is_mod  = (r_op == sacm_pkg::OP_MODIFY);
        hit_inc = 2'((r_kind == sacm_pkg::OUT_HIT) ? 1 : 0) + 2'(is_mod ? 1 : 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= sacm_pkg::STAMP_W'(1);
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit) begin
                r_time      <= r_time + 1'b1;
                if (r_kind != sacm_pkg::OUT_NONE) begin
                    r_hits <= r_hits + sacm_pkg::CNT_W'(hit_inc);
                    if (r_kind != sacm_pkg::OUT_HIT) begin
                        r_misses <= r_misses + 1'b1;
                    end
                    if (r_kind == sacm_pkg::OUT_EVICT) begin
                        r_evicts <= r_evicts + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_outcome <= r_kind;
            r_second  <= is_mod;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.outcome     = r_outcome;
    assign o_out.second_hit  = r_second;
    assign o_out.hit_total   = r_hits;
    assign o_out.miss_total  = r_misses;
    assign o_out.evict_total = r_evicts;
endmodule

// ===== hw/rtl/sacm_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module sacm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== verif/tb_set_assoc_lru_cache_model.sv =====
// Self-checking testbench for the set-associative LRU cache model: directed table, then random phases.
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_model;
    import sacm_pkg::*;

    // Geometry limits of the instance under test; the scoreboard cache uses the same shape.
    localparam int SET_BITS_MAX = 6;
    localparam int WAYS_MAX     = 8;
    localparam int LINE_TOTAL   = (1 << SET_BITS_MAX) * WAYS_MAX;

    // The one register index that maps to nothing; a write there must change no setting.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Random part: a fresh register setting is loaded before each phase.
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 84;
    // Results the receiver lets through before its one long hold-off, and its length.
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 250;

    // One result item, field for field as the output channel carries it.
    typedef struct packed {
        logic [OUT_W-1:0] outcome;
        logic             second_hit;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] evict_total;
    } t_result;

    // One row of the directed table. Where use_typed is set, the result is written out by
    // hand; elsewhere the scoreboard cache supplies it.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic              use_typed;
        t_result           want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    sacm_in_if  acc_if ();
    sacm_out_if res_if ();
    sacm_cfg_if cfg_if ();

    set_assoc_lru_cache_model #(
        .MAX_SET_BITS(SET_BITS_MAX),
        .MAX_WAYS    (WAYS_MAX)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (acc_if),
        .o_out  (res_if),
        .i_cfg  (cfg_if)
    );

    // Scoreboard copy of the cache: lines, stamps, counters and the three registers as
    // the block should hold them after every accepted item and register write.
    logic               cache_valid [LINE_TOTAL];
    logic [ADDR_W-1:0]  cache_tag   [LINE_TOTAL];
    logic [STAMP_W-1:0] cache_stamp [LINE_TOTAL];
    logic [STAMP_W-1:0] now_stamp;
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
    logic [CNT_W-1:0]   evict_count;
    logic [2:0]         reg_set_bits;
    logic [3:0]         reg_ways;
    logic [4:0]         reg_block_bits;

    // Results still owed by the block, oldest first.
    t_result     awaited[$];
    t_dir_row    directed_rows[$];
    int unsigned mismatch_count;
    int unsigned op_tally [4];
    bit          quiet_tail;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // One lookup in the scoreboard cache. A hit refreshes the stamp; a miss fills the
    // highest invalid way, or else replaces the oldest stamp, lowest way winning a tie.
    function automatic logic [OUT_W-1:0] cache_lookup(input logic [ADDR_W-1:0] addr);
        int unsigned       sb;
        int unsigned       nw;
        int unsigned       bb;
        int unsigned       base;
        int unsigned       pick;
        logic [ADDR_W-1:0] tag;
        bit                found;
        sb   = clamp_to(32'(reg_set_bits), 1, SET_BITS_MAX);
        nw   = clamp_to(32'(reg_ways), 1, WAYS_MAX);
        bb   = 32'(reg_block_bits);
        // A shift past the address width leaves an empty tag.
        tag  = (sb + bb >= ADDR_W) ? '0 : addr >> (sb + bb);
        base = ((addr >> bb) & ((1 << sb) - 1)) * WAYS_MAX;
        for (int w = 0; w < nw; w++) begin
            if (cache_valid[base + w] && cache_tag[base + w] == tag) begin
                cache_stamp[base + w] = now_stamp;
                hit_count++;
                return OUT_HIT;
            end
        end
        miss_count++;
        found = 1'b0;
        pick  = 0;
        for (int w = 0; w < nw; w++) begin
            if (!cache_valid[base + w]) begin
                pick  = w;
                found = 1'b1;
            end
        end
        if (found) begin
            cache_valid[base + pick] = 1'b1;
            cache_tag[base + pick]   = tag;
            cache_stamp[base + pick] = now_stamp;
            return OUT_FILL;
        end
        evict_count++;
        pick = 0;
        for (int w = 1; w < nw; w++) begin
            if (cache_stamp[base + w] < cache_stamp[base + pick]) begin
                pick = w;
            end
        end
        cache_tag[base + pick]   = tag;
        cache_stamp[base + pick] = now_stamp;
        return OUT_EVICT;
    endfunction

    // Result of one access. A modify's store part looks up the same line again, which
    // always hits and counts. Every item, ignored ones too, moves the time stamp on.
    function automatic t_result predict_access(input logic [OP_W-1:0] op,
                                               input logic [ADDR_W-1:0] addr);
        t_result r;
        r.outcome    = OUT_NONE;
        r.second_hit = 1'b0;
        case (op)
            OP_LOAD, OP_STORE: begin
                r.outcome = cache_lookup(addr);
            end
            OP_MODIFY: begin
                r.outcome    = cache_lookup(addr);
                r.second_hit = (cache_lookup(addr) == OUT_HIT);
            end
            default: begin
            end
        endcase
        now_stamp++;
        r.hit_total   = hit_count;
        r.miss_total  = miss_count;
        r.evict_total = evict_count;
        return r;
    endfunction

    function automatic t_dir_row dir_row(input logic [OP_W-1:0] op,
                                         input logic [ADDR_W-1:0] addr,
                                         input int unsigned use_typed,
                                         input logic [OUT_W-1:0] outcome,
                                         input int unsigned second_hit, input int unsigned hits,
                                         input int unsigned misses, input int unsigned evicts);
        t_dir_row row;
        row.op        = op;
        row.address   = addr;
        row.use_typed = 1'(use_typed);
        row.want      = '{outcome, 1'(second_hit), hits, misses, evicts};
        return row;
    endfunction

    // Offers one access item, sometimes after a random gap, and records its result once
    // the block takes it. Valid stays high between items offered back to back.
    task automatic offer_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic use_typed, input t_result want);
        t_result r;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            acc_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        acc_if.valid   <= 1'b1;
        acc_if.op      <= op;
        acc_if.address <= addr;
        do @(posedge i_clk); while (!acc_if.ready);
        r = predict_access(op, addr);
        awaited.push_back(use_typed ? want : r);
        op_tally[op]++;
    endtask

    // One register write. The caller lowers valid after the last write of a group.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_SET_BITS:   reg_set_bits   = value[2:0];
            CFG_WAYS:       reg_ways       = value[3:0];
            CFG_BLOCK_BITS: reg_block_bits = value;
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h",
                     $time, name, want, got);
        end
    endtask

    // Result checker: every accepted result item is matched against the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: expected no result item, got one with outcome %0d",
                         $time, res_if.outcome);
            end else begin
                want = awaited.pop_front();
                check_field("outcome", 32'(want.outcome), 32'(res_if.outcome));
                check_field("second_hit", 32'(want.second_hit), 32'(res_if.second_hit));
                check_field("hit_total", want.hit_total, res_if.hit_total);
                check_field("miss_total", want.miss_total, res_if.miss_total);
                check_field("evict_total", want.evict_total, res_if.evict_total);
            end
        end
    end

    // Receiver. It stalls in random bursts, except in the quiet tail of the run, and once
    // holds off for a long stretch so that the block backs up and refuses new items.
    initial begin : result_sink
        int unsigned taken;
        int unsigned hold_left;
        int unsigned gap_left;
        bit          held_once;
        taken     = 0;
        hold_left = 0;
        gap_left  = 0;
        held_once = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!held_once && taken >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                res_if.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 15) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [OP_W-1:0]       op;
        logic [ADDR_W-1:0]     addr;
        logic [63:0]           wide;
        logic [CFG_DATA_W-1:0] set_val;
        logic [CFG_DATA_W-1:0] ways_val;
        logic [CFG_DATA_W-1:0] block_val;
        int unsigned           sb;
        int unsigned           nw;
        int unsigned           bb;
        int unsigned           pick;

        mismatch_count = 0;
        quiet_tail     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            op_tally[i] = 0;
        end
        // Every line starts invalid; the tags are never read before they are written.
        for (int i = 0; i < LINE_TOTAL; i++) begin
            cache_valid[i] = 1'b0;
            cache_tag[i]   = '0;
            cache_stamp[i] = '0;
        end
        now_stamp      = 1;
        hit_count      = 0;
        miss_count     = 0;
        evict_count    = 0;
        reg_set_bits   = SET_BITS_RESET;
        reg_ways       = WAYS_RESET;
        reg_block_bits = BLOCK_BITS_RESET;

        i_rst_n        <= 1'b0;
        acc_if.valid   <= 1'b0;
        acc_if.op      <= OP_LOAD;
        acc_if.address <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= CFG_SET_BITS;
        cfg_if.data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset geometry: 16 sets, one way, 16-byte blocks.
        // The first rows are simple enough to spell out: fills, a hit in the same block, a
        // conflict that evicts, a modify whose store part hits, ignored records, and both
        // address extremes. The rest come from the scoreboard.
        directed_rows.push_back(dir_row(OP_LOAD,   32'h0000_0000, 1, OUT_FILL,  0, 0, 1, 0));
        directed_rows.push_back(dir_row(OP_LOAD,   32'h0000_000F, 1, OUT_HIT,   0, 1, 1, 0));
        directed_rows.push_back(dir_row(OP_STORE,  32'h0000_0100, 1, OUT_EVICT, 0, 1, 2, 1));
        directed_rows.push_back(dir_row(OP_MODIFY, 32'h0000_0100, 1, OUT_HIT,   1, 3, 2, 1));
        directed_rows.push_back(dir_row(OP_IGNORE, 32'hFFFF_FFFF, 1, OUT_NONE,  0, 3, 2, 1));
        directed_rows.push_back(dir_row(OP_MODIFY, 32'hFFFF_FFFF, 1, OUT_FILL,  1, 4, 3, 1));
        directed_rows.push_back(dir_row(OP_STORE,  32'hFFFF_FFF0, 1, OUT_HIT,   0, 5, 3, 1));
        directed_rows.push_back(dir_row(OP_LOAD,   32'h0000_0000, 1, OUT_EVICT, 0, 5, 4, 2));
        directed_rows.push_back(dir_row(OP_IGNORE, 32'h0000_0000, 1, OUT_NONE,  0, 5, 4, 2));
        directed_rows.push_back(dir_row(OP_LOAD,   32'hAAAA_AAAA, 0, OUT_NONE,  0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_STORE,  32'h5555_5555, 0, OUT_NONE,  0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_MODIFY, 32'hAAAA_AAAA, 0, OUT_NONE,  0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_LOAD,   32'h5555_5555, 0, OUT_NONE,  0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_STORE,  32'h8000_0000, 0, OUT_NONE,  0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_LOAD,   32'h7FFF_FFFF, 0, OUT_NONE,  0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_MODIFY, 32'h0000_0001, 0, OUT_NONE,  0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_IGNORE, 32'h1234_5678, 0, OUT_NONE,  0, 0, 0, 0));
        directed_rows.push_back(dir_row(OP_LOAD,   32'h0000_00F0, 0, OUT_NONE,  0, 0, 0, 0));
        foreach (directed_rows[i]) begin
            offer_access(directed_rows[i].op, directed_rows[i].address,
                         directed_rows[i].use_typed, directed_rows[i].want);
        end
        acc_if.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            // Registers change only once the block has returned everything it owes.
            while (awaited.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            // The first settings walk the extremes: smallest geometry, largest, values
            // below range that must saturate up, values above range that must saturate
            // down together with a tag shift past 32 bits. Later ones are random.
            case (p)
                0: begin
                    set_val = 5'd1;  ways_val = 5'd1;  block_val = 5'd1;
                end
                1: begin
                    set_val = 5'd6;  ways_val = 5'd8;  block_val = 5'd25;
                end
                2: begin
                    set_val = 5'd0;  ways_val = 5'd0;  block_val = 5'd0;
                end
                3: begin
                    set_val = 5'd31; ways_val = 5'd31; block_val = 5'd31;
                end
                4: begin
                    set_val = 5'd3;  ways_val = 5'd4;  block_val = 5'd2;
                end
                5: begin
                    set_val = 5'd2;  ways_val = 5'd8;  block_val = 5'd12;
                end
                default: begin
                    set_val   = CFG_DATA_W'($urandom);
                    ways_val  = CFG_DATA_W'($urandom);
                    block_val = CFG_DATA_W'($urandom);
                end
            endcase
            write_register(CFG_SET_BITS, set_val);
            write_register(CFG_WAYS, ways_val);
            write_register(CFG_BLOCK_BITS, block_val);
            // A write to the unmapped index must leave the geometry alone.
            if (p == 4) begin
                write_register(CFG_UNUSED, 5'h1F);
            end
            cfg_if.valid <= 1'b0;
            // The last phase runs with no gaps on either side.
            if (p == PHASES - 1) begin
                quiet_tail = 1'b1;
            end

            sb = clamp_to(32'(reg_set_bits), 1, SET_BITS_MAX);
            nw = clamp_to(32'(reg_ways), 1, WAYS_MAX);
            bb = 32'(reg_block_bits);
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    op = OP_LOAD;
                end else if (pick < 6) begin
                    op = OP_STORE;
                end else if (pick < 9) begin
                    op = OP_MODIFY;
                end else begin
                    op = OP_IGNORE;
                end
                // Most addresses pick from a few tags over a few sets, slightly more tags
                // than ways, so hits, fills and evictions all happen often. The rest are
                // fully random and toggle every address bit.
                if ($urandom_range(0, 9) < 7) begin
                    wide = (64'($urandom_range(0, nw + 2)) << (sb + bb))
                         | (64'($urandom_range(0, 3) & ((1 << sb) - 1)) << bb)
                         | (64'($urandom) & ((64'd1 << bb) - 1));
                    addr = wide[ADDR_W-1:0];
                end else begin
                    addr = $urandom;
                end
                offer_access(op, addr, 1'b0, '0);
            end
            acc_if.valid <= 1'b0;
        end

        // Wait for the last results, then keep watching for any stray result item.
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d loads, %0d stores, %0d modifies, %0d ignored records",
                 op_tally[OP_LOAD], op_tally[OP_STORE], op_tally[OP_MODIFY],
                 op_tally[OP_IGNORE]);
        $display("over %0d register settings; cache saw %0d hits, %0d misses, %0d evictions",
                 PHASES + 1, hit_count, miss_count, evict_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard limit, far above the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d result items still expected", awaited.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
